[src/rcfd_pkg.sv]
// shared types and constants for the radar can frame decoder
package rcfd_pkg;

    localparam logic [1:0] KIND_RANGE  = 2'd0;
    localparam logic [1:0] KIND_BIN    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [10:0] ID_STATUS = 11'h60A;
    localparam logic [10:0] ID_TARGET = 11'h60B;
    localparam logic [10:0] ID_RANGE  = 11'h70C;
    localparam logic [10:0] ID_MASK   = 11'h70F;

    localparam logic [7:0]  VOTE_RESET = 8'd100;
    localparam logic [7:0]  VOTE_SUM   = 8'd200;
    localparam logic [19:0] TIMEOUT_RESET = 20'd5000;
    localparam int          DEG60  = 3932160;
    localparam int          DEG120 = 7864320;

    // datapath command
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ,
        CMD_SQRT_STEP,
        CMD_PREROT,
        CMD_CORDIC_STEP,
        CMD_BIN_MUL,
        CMD_BIN_DIV_STEP,
        CMD_BIN_RD,
        CMD_BIN_WR,
        CMD_CLR_WR,
        CMD_EMIT_RD
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] idx;
    } t_ctl;

    typedef struct packed {
        logic       bin_ok;
        logic [5:0] bin;
    } t_sts;

    function automatic logic [22:0] atan_tab(input logic [3:0] i);
        logic [22:0] v;
        unique case (i)
            4'd0:  v = 23'd2949120;
            4'd1:  v = 23'd1740967;
            4'd2:  v = 23'd919879;
            4'd3:  v = 23'd466945;
            4'd4:  v = 23'd234379;
            4'd5:  v = 23'd117304;
            4'd6:  v = 23'd58666;
            4'd7:  v = 23'd29335;
            4'd8:  v = 23'd14668;
            4'd9:  v = 23'd7334;
            4'd10: v = 23'd3667;
            4'd11: v = 23'd1833;
            4'd12: v = 23'd917;
            4'd13: v = 23'd458;
            4'd14: v = 23'd229;
            default: v = 23'd115;
        endcase
        return v;
    endfunction

endpackage

[src/rcfd_ram.sv]
// generic single port ram with registered read
module rcfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/rcfd_datapath.sv]
// target geometry datapath: distance root, cordic bearing, bin search and bin store
module rcfd_datapath #(
    parameter int SCAN_BINS = 64
) (
    input  logic             i_clk,
    input  rcfd_pkg::t_ctl   i_ctl,
    input  logic [63:0]      i_payload,
    output logic [15:0]      o_bin_rdata
);
    localparam int BW = $clog2(SCAN_BINS);
    localparam logic [12:0] RECIP15 = 13'd4370;

    logic signed [12:0] r_x;
    logic signed [13:0] r_y;
    logic [25:0]        r_sq;
    logic [17:0]        r_root;
    logic [35:0]        r_rem;
    logic [15:0]        r_dist;
    logic signed [31:0] r_a, r_b;
    logic signed [24:0] r_acc;
    logic signed [31:0] r_t;
    logic [8:0]         r_q;
    logic [35:0]        r_den;

    logic [7:0]  b1, b2, b3;
    logic [3:0]  step;
    logic signed [31:0] sa, sb;
    logic        we;
    logic [5:0]  addr;
    logic [15:0] wdata, rdata;
    rcfd_pkg::t_sts sts;

    assign b1 = i_payload[55:48];
    assign b2 = i_payload[47:40];
    assign b3 = i_payload[39:32];
    assign step = i_ctl.idx[3:0];
    assign sa = r_a >>> step;
    assign sb = r_b >>> step;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            rcfd_pkg::CMD_LOAD: begin
                r_x <= 13'(signed'({2'b00, b2[2:0], b3})) - 13'sd1023;
                r_y <= 14'(signed'({1'b0, b1, b2[7:3]})) - 14'sd2500;
            end
            rcfd_pkg::CMD_SQ: begin
                r_sq   <= 26'(r_x * r_x) + 26'(r_y * r_y);
                r_root <= '0;
                r_rem  <= '0;
                r_den  <= '0;
            end
            rcfd_pkg::CMD_SQRT_STEP: begin
                // 400*(x*x+y*y) < 2^34, root in 18 bits: one result bit a step
                if (i_ctl.idx == 6'd0) begin
                    r_den <= 36'(r_sq) * 36'd400;
                end else begin
                    r_den <= {r_den[33:0], 2'b00};
                    if ({r_rem[33:0], r_den[35:34]} >= {16'd0, r_root, 2'b01}) begin
                        r_rem  <= {r_rem[33:0], r_den[35:34]} - {16'd0, r_root, 2'b01};
                        r_root <= {r_root[16:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[33:0], r_den[35:34]};
                        r_root <= {r_root[16:0], 1'b0};
                    end
                end
            end
            rcfd_pkg::CMD_PREROT: begin
                r_dist <= (r_root[17:16] != 2'b00) ? 16'hFFFF : r_root[15:0];
                if (r_y < 0) begin
                    if (r_x >= 0) begin
                        r_a <= 32'(r_x) <<< 16;
                        r_b <= -(32'(r_y) <<< 16);
                        r_acc <= 25'sd5898240;
                    end else begin
                        r_a <= -(32'(r_x) <<< 16);
                        r_b <= 32'(r_y) <<< 16;
                        r_acc <= -25'sd5898240;
                    end
                end else begin
                    r_a <= 32'(r_y) <<< 16;
                    r_b <= 32'(r_x) <<< 16;
                    r_acc <= '0;
                end
            end
            rcfd_pkg::CMD_CORDIC_STEP: begin
                if (r_b >= 0) begin
                    r_a <= r_a + sb;
                    r_b <= r_b - sa;
                    r_acc <= r_acc + 25'(signed'({1'b0, rcfd_pkg::atan_tab(step)}));
                end else begin
                    r_a <= r_a - sb;
                    r_b <= r_b + sa;
                    r_acc <= r_acc - 25'(signed'({1'b0, rcfd_pkg::atan_tab(step)}));
                end
            end
            rcfd_pkg::CMD_BIN_MUL: begin
                if (r_x == 0 && r_y == 0) begin
                    r_t <= 32'(rcfd_pkg::DEG60 * (SCAN_BINS - 1) + rcfd_pkg::DEG60);
                end else begin
                    r_t <= 32'(r_acc) * 32'(SCAN_BINS - 1)
                         + 32'(rcfd_pkg::DEG60 * (SCAN_BINS - 1) + rcfd_pkg::DEG60);
                end
                r_q <= '0;
            end
            rcfd_pkg::CMD_BIN_DIV_STEP: begin
                // t / (15 * 2^19): drop the power of two, then multiply by 2^16 / 15 rounded up
                r_q <= 9'((26'(r_t[30:19]) * 26'(RECIP15)) >> 16);
            end
            default: ;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        addr  = i_ctl.idx;
        wdata = 16'hFFFF;
        unique case (i_ctl.cmd)
            rcfd_pkg::CMD_BIN_RD:  addr = sts.bin;
            rcfd_pkg::CMD_BIN_WR: begin
                addr  = sts.bin;
                we    = sts.bin_ok && (rdata > r_dist);
                wdata = r_dist;
            end
            rcfd_pkg::CMD_CLR_WR: we = 1'b1;
            default: ;
        endcase
    end

    rcfd_ram #(.WIDTH(16), .DEPTH(64)) u_bins (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    assign sts.bin_ok  = !r_t[31] && (32'(r_q) < 32'(SCAN_BINS));
    assign sts.bin     = 6'(r_q[BW-1:0]);
    assign o_bin_rdata = rdata;
endmodule

[src/rcfd_ctrl.sv]
// frame classification and sequencing of the decoder
module rcfd_ctrl #(
    parameter int SCAN_BINS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [19:0]    i_scan_timeout_us,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_command,
    input  logic [28:0]    i_frame_id,
    input  logic           i_is_error,
    input  logic           i_is_remote,
    input  logic [3:0]     i_length_code,
    input  logic [63:0]    i_payload,
    input  logic [31:0]    i_now_us,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [3:0]     o_sensor_address,
    output logic [19:0]    o_range_cm,
    output logic [5:0]     o_bin_index,
    output logic [15:0]    o_bin_distance_cm,
    output logic [31:0]    o_stamp_us,
    output logic           o_last,
    output logic [63:0]    o_dp_payload,
    output rcfd_pkg::t_ctl o_ctl,
    input  logic [15:0]    i_bin_rdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SQ, S_SQRT, S_PREROT, S_CORDIC, S_MUL, S_DIV,
        S_BRD, S_BWR, S_FIN, S_EMRD, S_EMWAIT, S_OUT
    } t_state;

    t_state      r_state;
    logic [19:0] r_timeout;
    logic [7:0]  r_exp, r_rcv, r_vote;
    logic [3:0]  r_addr;
    logic [31:0] r_ltime, r_stamp;
    logic [63:0] r_pl;
    logic [6:0]  r_cnt;
    logic        r_ovalid, r_olast;
    logic [1:0]  r_kind;
    logic [3:0]  r_osa;
    logic [19:0] r_range;
    logic [5:0]  r_bidx;
    logic [15:0] r_bdist;
    logic [31:0] r_ostamp;

    logic        acc_in, rej;
    logic [10:0] ftype;
    logic [3:0]  faddr;
    logic [7:0]  sum, nrcv;
    logic [7:0]  b[8];

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign acc_in  = i_valid && o_ready;
    assign ftype   = i_frame_id[10:0] & rcfd_pkg::ID_MASK;
    assign faddr   = i_frame_id[7:4];
    assign rej     = i_is_error || i_is_remote || (i_frame_id[28:11] != '0)
                     || (i_length_code != 4'd8);
    assign nrcv    = r_rcv + 8'd1;

    always_comb begin
        for (int k = 0; k < 8; k++) b[k] = i_payload[63-8*k -: 8];
        sum = b[0] + b[1] + b[2] + b[3] + b[4] + b[5] + b[6];
    end

    always_comb begin
        o_ctl.cmd = rcfd_pkg::CMD_NONE;
        o_ctl.idx = 6'(r_cnt);
        unique case (r_state)
            S_IDLE:   if (acc_in) o_ctl.cmd = rcfd_pkg::CMD_LOAD;
            S_CLEAR:  o_ctl.cmd = rcfd_pkg::CMD_CLR_WR;
            S_SQ:     o_ctl.cmd = rcfd_pkg::CMD_SQ;
            S_SQRT:   o_ctl.cmd = rcfd_pkg::CMD_SQRT_STEP;
            S_PREROT: o_ctl.cmd = rcfd_pkg::CMD_PREROT;
            S_CORDIC: o_ctl.cmd = rcfd_pkg::CMD_CORDIC_STEP;
            S_MUL:    o_ctl.cmd = rcfd_pkg::CMD_BIN_MUL;
            S_DIV:    o_ctl.cmd = rcfd_pkg::CMD_BIN_DIV_STEP;
            S_BRD:    o_ctl.cmd = rcfd_pkg::CMD_BIN_RD;
            S_BWR:    o_ctl.cmd = rcfd_pkg::CMD_BIN_WR;
            S_EMRD:   o_ctl.cmd = rcfd_pkg::CMD_EMIT_RD;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= rcfd_pkg::TIMEOUT_RESET;
            r_exp     <= '0;
            r_rcv     <= '0;
            r_vote    <= rcfd_pkg::VOTE_RESET;
            r_addr    <= '0;
            r_ltime   <= '0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_timeout <= i_scan_timeout_us;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    r_pl <= i_payload;
                    r_cnt <= '0;
                    r_kind <= rcfd_pkg::KIND_RANGE;
                    r_osa <= faddr;
                    r_range <= '0;
                    r_bidx <= '0;
                    r_bdist <= '0;
                    r_ostamp <= '0;
                    r_olast <= 1'b0;
                    if (i_command) begin
                        if (r_rcv != 0 && (i_now_us - r_ltime) >= 32'(r_timeout)) begin
                            r_stamp <= r_ltime;
                            r_exp <= '0;
                            r_rcv <= '0;
                            r_state <= S_EMRD;
                        end
                    end else if (rej) begin
                        r_kind <= rcfd_pkg::KIND_REJECT;
                        r_ovalid <= 1'b1;
                    end else if (ftype == rcfd_pkg::ID_STATUS) begin
                        if (r_addr == faddr) begin
                            r_exp <= b[0];
                            r_rcv <= '0;
                            r_state <= S_CLEAR;
                        end
                    end else if (ftype == rcfd_pkg::ID_TARGET) begin
                        r_addr <= faddr;
                        if (r_exp != 0) begin
                            r_ltime <= i_now_us;
                            r_stamp <= i_now_us;
                            r_state <= S_SQ;
                        end
                    end else if (ftype == rcfd_pkg::ID_RANGE) begin
                        if (r_vote == 8'd0) begin
                            r_range <= {4'd0, b[2], b[3]};
                            r_ovalid <= 1'b1;
                        end else if (r_vote == rcfd_pkg::VOTE_SUM) begin
                            if (sum == b[7]) begin
                                r_range <= {b[0][7:4], b[2], b[3]};
                                r_ovalid <= 1'b1;
                            end
                        end else if (sum == b[7]) begin
                            r_vote <= r_vote + 8'd1;
                        end else begin
                            r_vote <= r_vote - 8'd1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_IDLE;
                end
                S_SQ: r_state <= S_SQRT;
                S_SQRT: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd18) begin
                        r_cnt <= '0;
                        r_state <= S_PREROT;
                    end
                end
                S_PREROT: r_state <= S_CORDIC;
                S_CORDIC: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd15) r_state <= S_MUL;
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: r_state <= S_BRD;
                S_BRD: r_state <= S_BWR;
                S_BWR: r_state <= S_FIN;
                S_FIN: begin
                    r_cnt <= '0;
                    if (nrcv == r_exp) begin
                        r_exp <= '0;
                        r_rcv <= '0;
                        r_state <= S_EMRD;
                    end else begin
                        r_rcv <= nrcv;
                        r_state <= S_IDLE;
                    end
                end
                S_EMRD: if (!r_ovalid || i_ready) r_state <= S_EMWAIT;
                S_EMWAIT: r_state <= S_OUT;
                S_OUT: begin
                    r_kind   <= rcfd_pkg::KIND_BIN;
                    r_osa    <= r_addr;
                    r_range  <= '0;
                    r_bidx   <= 6'(r_cnt);
                    r_bdist  <= i_bin_rdata;
                    r_ostamp <= r_stamp;
                    r_olast  <= (r_cnt == 7'(SCAN_BINS - 1));
                    r_ovalid <= 1'b1;
                    r_cnt    <= r_cnt + 7'd1;
                    r_state  <= (r_cnt == 7'(SCAN_BINS - 1)) ? S_IDLE : S_EMRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_kind            = r_kind;
    assign o_sensor_address  = r_osa;
    assign o_range_cm        = r_range;
    assign o_bin_index       = r_bidx;
    assign o_bin_distance_cm = r_bdist;
    assign o_stamp_us        = r_ostamp;
    assign o_last            = r_olast;
    assign o_dp_payload      = (r_state == S_IDLE) ? i_payload : r_pl;
endmodule

[src/radar_can_frame_decoder.sv]
// top level of the radar can frame decoder
// Input channel (i_valid/o_ready) takes one request: a CAN frame (i_command 0)
// or a time tick (i_command 1). Output channel (o_valid/i_ready) gives results
// one at a time from an output register.
// Rejected frames and range frames (once the vote has settled): result in
// the cycle after acceptance. Status frames matching the stored sensor
// address clear the 64 bins in one pass; a tick emitting a scan or the target
// frame completing one yields SCAN_BINS bin results through emit read, wait
// and output states, one bin store read each. A target frame, if a scan is
// expected: square, root, pre-rotation, 16 cordic steps, a multiply and a
// reciprocal divide for the bin, then bin store read and write, count update.
// One request is worked at a time; o_ready is low while a request is in
// progress or a result waits. A stalled receiver holds the result and the
// sequencer. The configuration channel is always ready and sets the scan
// timeout. Reset clears counts, the vote (to 100) and the timeout (to 5000);
// bins are undefined after reset until a status frame clears them.
module radar_can_frame_decoder #(
    parameter int SCAN_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_scan_timeout_us,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [28:0] i_frame_id,
    input  logic        i_is_error,
    input  logic        i_is_remote,
    input  logic [3:0]  i_length_code,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_now_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_sensor_address,
    output logic [19:0] o_range_cm,
    output logic [5:0]  o_bin_index,
    output logic [15:0] o_bin_distance_cm,
    output logic [31:0] o_stamp_us,
    output logic        o_last
);
    rcfd_pkg::t_ctl ctl;
    logic [15:0]    bin_rdata;
    logic [63:0]    dp_payload;

    rcfd_ctrl #(.SCAN_BINS(SCAN_BINS)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_scan_timeout_us,
        .i_valid, .o_ready, .i_command, .i_frame_id, .i_is_error, .i_is_remote,
        .i_length_code, .i_payload, .i_now_us, .o_valid, .i_ready, .o_kind,
        .o_sensor_address, .o_range_cm, .o_bin_index, .o_bin_distance_cm,
        .o_stamp_us, .o_last,
        .o_dp_payload(dp_payload),
        .o_ctl(ctl),
        .i_bin_rdata(bin_rdata)
    );

    rcfd_datapath #(.SCAN_BINS(SCAN_BINS)) u_dp (
        .i_clk,
        .i_ctl(ctl),
        .i_payload(dp_payload),
        .o_bin_rdata(bin_rdata)
    );
endmodule
